// File: rtl/mar_pkg.sv
// ----------------------------------------------------------------------------
// mar_pkg
// Shared types, codes and the modular add step of the modular arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

package mar_pkg;

  localparam int WordBits = 64;

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [2:0] {
    ActAdd    = 3'd0,
    ActSub    = 3'd1,
    ActNeg    = 3'd2,
    ActMul    = 3'd3,
    ActReduce = 3'd4,
    ActCmp    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    OrdEqual   = 2'd0,
    OrdLess    = 2'd1,
    OrdGreater = 2'd2
  } order_e;

  // reduction pipeline payload
  typedef struct packed {
    logic       valid;
    logic [2:0] act;
    word_t      sa;
    word_t      sb;
    word_t      ra;
    word_t      rb;
  } red_t;

  // multiply pipeline payload
  typedef struct packed {
    logic       valid;
    logic [2:0] act;
    word_t      ra;
    word_t      rb;
    word_t      ysh;
    word_t      acc;
  } mul_t;

  // (acc + addend + cin) reduced once against m
  function automatic word_t mod_step(word_t acc, word_t addend, logic cin, word_t m);
    logic [WordBits:0] s;
    s = {1'b0, acc} + {1'b0, addend} + {{WordBits{1'b0}}, cin};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WordBits-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/mar_red_cell.sv
// ----------------------------------------------------------------------------
// mar_red_cell
// One bit step of the operand reduction chain for both operands
// ----------------------------------------------------------------------------
`default_nettype none

module mar_red_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire mar_pkg::word_t modulus_i,
  input  wire mar_pkg::red_t stage_i,
  output mar_pkg::red_t      stage_o
);
  import mar_pkg::*;

  red_t stage_d, stage_q;
  logic valid_q;

  always_comb begin
    stage_d    = stage_i;
    stage_d.sa = {stage_i.sa[WordBits-2:0], 1'b0};
    stage_d.sb = {stage_i.sb[WordBits-2:0], 1'b0};
    stage_d.ra = mod_step(stage_i.ra, stage_i.ra, stage_i.sa[WordBits-1], modulus_i);
    stage_d.rb = mod_step(stage_i.rb, stage_i.rb, stage_i.sb[WordBits-1], modulus_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

`default_nettype wire

// File: rtl/mar_mul_cell.sv
// ----------------------------------------------------------------------------
// mar_mul_cell
// One multiplier bit of the double-and-add chain, doubling then adding
// ----------------------------------------------------------------------------
`default_nettype none

module mar_mul_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire mar_pkg::word_t modulus_i,
  input  wire mar_pkg::mul_t stage_i,
  output mar_pkg::mul_t      stage_o
);
  import mar_pkg::*;

  mul_t dbl_d, dbl_q, add_d, add_q;
  logic dbl_valid_q, add_valid_q;

  always_comb begin
    dbl_d     = stage_i;
    dbl_d.acc = mod_step(stage_i.acc, stage_i.acc, 1'b0, modulus_i);
  end

  always_comb begin
    add_d       = dbl_q;
    add_d.valid = dbl_valid_q;
    add_d.ysh   = {dbl_q.ysh[WordBits-2:0], 1'b0};
    if (dbl_q.ysh[WordBits-1]) begin
      add_d.acc = mod_step(dbl_q.acc, dbl_q.ra, 1'b0, modulus_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbl_valid_q <= 1'b0;
      add_valid_q <= 1'b0;
    end else if (en_i) begin
      dbl_valid_q <= dbl_d.valid;
      add_valid_q <= add_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dbl_q <= dbl_d;
      add_q <= add_d;
    end
  end

  always_comb begin
    stage_o       = add_q;
    stage_o.valid = add_valid_q;
  end

endmodule

`default_nettype wire

// File: rtl/modular_alu_single_word.sv
// ----------------------------------------------------------------------------
// modular_alu_single_word
// Modular add, subtract, negate, multiply, reduce and compare over one word
//
// channel   signals                                              direction
// input     in_valid_i in_ready_o action_i operand_a_i operand_b_i  in
// output    out_valid_o out_ready_i value_o order_o              out
// config    modulus_we_i modulus_wdata_i                         in
//
// one transaction accepted per cycle unless the chain is stalled; the stages are:
// 64 reduction cells, 64 multiply cells of two stages each, one output stage
// the whole chain advances only when the output register is free or taken
// reset clears valid flags only; modulus resets to 2^61-1
// ----------------------------------------------------------------------------
`default_nettype none

module modular_alu_single_word (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                modulus_we_i,
  input  wire mar_pkg::word_t      modulus_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [2:0]          action_i,
  input  wire mar_pkg::word_t      operand_a_i,
  input  wire mar_pkg::word_t      operand_b_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output mar_pkg::word_t           value_o,
  output logic [1:0]               order_o
);
  import mar_pkg::*;

  localparam word_t ModulusReset = word_t'(64'd2305843009213693951);

  word_t modulus_q;
  logic  en;
  red_t  red_s [0:WordBits];
  mul_t  mul_s [0:WordBits];

  logic       out_valid_q;
  word_t      value_d, value_q;
  logic [1:0] order_d, order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
    end else if (modulus_we_i) begin
      modulus_q <= modulus_wdata_i;
    end
  end

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    red_s[0].valid = in_valid_i;
    red_s[0].act   = action_i;
    red_s[0].sa    = operand_a_i;
    red_s[0].sb    = operand_b_i;
    red_s[0].ra    = '0;
    red_s[0].rb    = '0;
  end

  for (genvar i = 0; i < WordBits; i++) begin : g_red
    mar_red_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .modulus_i (modulus_q),
      .stage_i   (red_s[i]),
      .stage_o   (red_s[i+1])
    );
  end

  always_comb begin
    mul_s[0].valid = red_s[WordBits].valid;
    mul_s[0].act   = red_s[WordBits].act;
    mul_s[0].ra    = red_s[WordBits].ra;
    mul_s[0].rb    = red_s[WordBits].rb;
    mul_s[0].ysh   = red_s[WordBits].rb;
    mul_s[0].acc   = '0;
  end

  for (genvar i = 0; i < WordBits; i++) begin : g_mul
    mar_mul_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .modulus_i (modulus_q),
      .stage_i   (mul_s[i]),
      .stage_o   (mul_s[i+1])
    );
  end

  always_comb begin
    mul_t f;
    f       = mul_s[WordBits];
    value_d = '0;
    order_d = OrdEqual;
    if (modulus_q >= word_t'(2)) begin
      case (f.act)
        ActAdd:    value_d = mod_step(f.ra, f.rb, 1'b0, modulus_q);
        ActSub:    value_d = (f.ra >= f.rb) ? f.ra - f.rb : f.ra - f.rb + modulus_q;
        ActNeg:    value_d = (f.ra == '0) ? '0 : modulus_q - f.ra;
        ActMul:    value_d = f.acc;
        ActReduce: value_d = f.ra;
        ActCmp: begin
          if (f.ra < f.rb) begin
            order_d = OrdLess;
          end else if (f.ra > f.rb) begin
            order_d = OrdGreater;
          end
        end
        default: value_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= mul_s[WordBits].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_q <= value_d;
      order_q <= order_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign order_o     = order_q;

  a_value_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (modulus_q >= word_t'(2)) |-> value_q < modulus_q)
    else $error("result not reduced");

  a_order_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (order_q != OrdEqual) |-> value_q == '0)
    else $error("compare result carries a value");

  a_order_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> order_q != 2'd3)
    else $error("bad order code");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(value_q) && $stable(order_q))
    else $error("chain moved during stall");

endmodule

`default_nettype wire

// File: verif/tb_modular_alu_single_word.sv
// ----------------------------------------------------------------------------
// tb_modular_alu_single_word
// Self-checking bench for the modular arithmetic unit: directed corner items,
// every action and unused code, several moduli including the extremes, then
// random transactions under varying source idling and sink stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_modular_alu_single_word;
  import mar_pkg::*;

  localparam int Latency    = 193;
  localparam int CycleLimit = 1500000;

  typedef struct packed {
    word_t      value;
    logic [1:0] order;
  } mod_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        modulus_we_i;
  word_t       modulus_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  action_i;
  word_t       operand_a_i;
  word_t       operand_b_i;
  logic        out_valid_o;
  logic        out_ready_i;
  word_t       value_o;
  logic [1:0]  order_o;

  word_t       cur_modulus;
  mod_result_t pending_results[$];
  int          src_idle_pct;
  int          sink_stall_pct;
  int          hold_cycles;
  int          n_sent;
  int          n_checked;
  int          n_errors;
  int          cycle_count;

  modular_alu_single_word dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .modulus_we_i   (modulus_we_i),
    .modulus_wdata_i(modulus_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .value_o        (value_o),
    .order_o        (order_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // expected result per action; products use a double-width remainder
  function automatic mod_result_t predict_mod_op(logic [2:0] act, word_t a, word_t b,
                                                 word_t m);
    mod_result_t     r;
    word_t           ra;
    word_t           rb;
    logic [64:0]     s;
    logic [127:0]    p;
    r = '0;
    if (m >= 2) begin
      ra = a % m;
      rb = b % m;
      case (act)
        ActAdd: begin
          s = {1'b0, ra} + {1'b0, rb};
          if (s >= {1'b0, m}) s = s - {1'b0, m};
          r.value = s[63:0];
        end
        ActSub:    r.value = (ra >= rb) ? ra - rb : ra - rb + m;
        ActNeg:    r.value = (ra == 0) ? '0 : m - ra;
        ActMul: begin
          p = {64'd0, ra} * {64'd0, rb};
          p = p % {64'd0, m};
          r.value = p[63:0];
        end
        ActReduce: r.value = ra;
        ActCmp:    r.order = (ra < rb) ? OrdLess : ((ra > rb) ? OrdGreater : OrdEqual);
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // operands biased toward the modulus boundary, small values and all-ones
  function automatic word_t pick_operand(word_t m);
    case ($urandom_range(0, 5))
      0: return rand_word();
      1: return m - 1;
      2: return m + word_t'($urandom_range(0, 3));
      3: return word_t'($urandom_range(0, 3));
      4: return '1 - word_t'($urandom_range(0, 3));
      default: return (m < 2) ? rand_word() : rand_word() % m;
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // sink stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    mod_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction value %h order %0d", value_o, order_o);
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (value_o !== exp_r.value) begin
          $error("value expected %h actual %h", exp_r.value, value_o);
          n_errors++;
        end
        if (order_o !== exp_r.order) begin
          $error("order expected %0d actual %0d", exp_r.order, order_o);
          n_errors++;
        end
        n_checked++;
      end
    end
  end

  task automatic send_item(logic [2:0] act, word_t a, word_t b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    operand_a_i <= a;
    operand_b_i <= b;
    pending_results.push_back(predict_mod_op(act, a, b, cur_modulus));
    n_sent++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
  endtask

  task automatic write_modulus(word_t m);
    drain();
    modulus_we_i    <= 1'b1;
    modulus_wdata_i <= m;
    @(posedge clk_i);
    modulus_we_i <= 1'b0;
    cur_modulus   = m;
  endtask

  task automatic test_directed();
    word_t m;
    m = cur_modulus;
    for (int act = 0; act < 8; act++) begin
      send_item(3'(act), m - 1, m - 2);
    end
    send_item(ActNeg, '0, '1);
    send_item(ActNeg, m, '0);
    send_item(ActAdd, '1, '1);
    send_item(ActMul, '1, '1);
    send_item(ActMul, m - 1, m - 1);
    send_item(ActSub, '0, m - 1);
    send_item(ActCmp, m, '0);
    send_item(ActCmp, '0, m + 1);
    send_item(ActCmp, '1, '0);
    send_item(ActReduce, '1, '0);
  endtask

  task automatic test_random(int n);
    logic [2:0] act;
    for (int i = 0; i < n; i++) begin
      act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                         : 3'($urandom_range(0, 5));
      send_item(act, pick_operand(cur_modulus), pick_operand(cur_modulus));
    end
  endtask

  task automatic test_moduli();
    word_t mods[6];
    mods = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 64'd0, 64'd1,
             64'hFFFF_FFFF_FFFF_FFC5, 64'h8000_0000_0000_0000};
    foreach (mods[k]) begin
      write_modulus(mods[k]);
      src_idle_pct = 0; sink_stall_pct = 0;
      test_directed();
      test_random(60);
    end
    write_modulus(rand_word());
    test_random(100);
  endtask

  task automatic test_idle_phases();
    int idle_set[4][2];
    idle_set = '{'{0, 0}, '{76, 0}, '{0, 76}, '{11, 11}};
    foreach (idle_set[k]) begin
      write_modulus((k == 0) ? 64'h1FFF_FFFF_FFFF_FFFF : rand_word() | 64'd2);
      src_idle_pct   = idle_set[k][0];
      sink_stall_pct = idle_set[k][1];
      test_random(250);
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_cycles    = 600;
    test_random(300);
    drain();
    test_random(50);
  endtask

  initial begin
    rst_ni          = 1'b0;
    modulus_we_i    = 1'b0;
    modulus_wdata_i = '0;
    in_valid_i      = 1'b0;
    action_i        = '0;
    operand_a_i     = '0;
    operand_b_i     = '0;
    cur_modulus     = 64'h1FFF_FFFF_FFFF_FFFF;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    hold_cycles     = 0;
    n_sent          = 0;
    n_checked       = 0;
    n_errors        = 0;
    cycle_count     = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_moduli();
    test_idle_phases();
    test_backpressure();
    drain();
    $display("covered %0d transactions sent, %0d results checked", n_sent, n_checked);
    $display("all actions, unused codes, 7 moduli incl. 0, 1, 2 and all-ones, idle and stalls");
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: modular_alu_single_word.f
rtl/mar_pkg.sv
rtl/mar_red_cell.sv
rtl/mar_mul_cell.sv
rtl/modular_alu_single_word.sv
verif/tb_modular_alu_single_word.sv
